// ===== hw/rtl/mpfb_pkg.sv =====
// Shared types, constants and helper functions of the max-pool forward/backward block.
package mpfb_pkg;

  localparam int DATA_W     = 16;
  localparam int COORD_W    = 6;
  localparam int CHAN_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int STRIDE_W   = 3;
  localparam int SIZE_W     = 7;
  localparam int DEPTH_W    = 5;
  localparam int OFS_W      = 2;
  localparam int SUM_W      = 21;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam int DEF_MAX_DEPTH  = 16;

  typedef enum logic [1:0] {
    OP_WR_SAMPLE = 2'd0,
    OP_RD_POOL   = 2'd1,
    OP_WR_GRAD   = 2'd2,
    OP_RD_GRAD   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_STRIDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_DEPTH    = 3'd4;

  localparam logic [STRIDE_W-1:0] RST_POOL_STRIDE = 3'd2;
  localparam logic [STRIDE_W-1:0] RST_WINDOW_SIZE = 3'd2;
  localparam logic [SIZE_W-1:0]   RST_IN_WIDTH    = 7'd64;
  localparam logic [SIZE_W-1:0]   RST_IN_HEIGHT   = 7'd64;
  localparam logic [DEPTH_W-1:0]  RST_IN_DEPTH    = 5'd16;

  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;
  localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'(32'sd32767);
  localparam logic signed [SUM_W-1:0]  SAT_LO   = SUM_W'(-32'sd32768);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COVER,
    S_MAX,
    S_MAX_TAIL,
    S_GRAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic               empty;
  } cover_t;

  // floor(n / s) for s in 1..4 and n below 128
  function automatic logic [SIZE_W-1:0] div_small(logic [SIZE_W-1:0] n,
                                                  logic [STRIDE_W-1:0] s);
    logic [12:0] prod;
    logic [SIZE_W-1:0] q;
    prod = {6'b0, n} * 13'd43;
    unique case (s)
      3'd1:    q = n;
      3'd2:    q = n >> 1;
      3'd3:    q = prod[12:7] == 6'd0 ? '0 : {1'b0, prod[12:7]};
      default: q = n >> 2;
    endcase
    return q;
  endfunction

  function automatic logic [COORD_W-1:0] mul_stride(logic [COORD_W-1:0] g,
                                                    logic [STRIDE_W-1:0] s);
    logic [COORD_W+STRIDE_W-1:0] prod;
    prod = {{STRIDE_W{1'b0}}, g} * {{COORD_W{1'b0}}, s};
    return prod[COORD_W-1:0];
  endfunction

  // first and last output window covering position p
  function automatic cover_t cover_range(logic [COORD_W-1:0] p, logic [STRIDE_W-1:0] k,
                                         logic [STRIDE_W-1:0] s, logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] pp1;
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    logic [SIZE_W-1:0] nm1;
    cover_t r;
    pp1 = {1'b0, p} + 7'd1;
    if (pp1 <= {4'b0, k}) begin
      lo = '0;
    end else begin
      lo = div_small(pp1 - {4'b0, k} + {4'b0, s} - 7'd1, s);
    end
    hi  = div_small({1'b0, p}, s);
    nm1 = n - 7'd1;
    if (n != '0 && hi > nm1) begin
      hi = nm1;
    end
    r.empty = (n == '0) || (lo > hi);
    r.lo    = lo[COORD_W-1:0];
    r.hi    = hi[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = DATA_MAX;
    end else if (v < SAT_LO) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mpfb_if.sv =====
// Channel interfaces of the max-pool block: request, result and configuration write.
interface mpfb_in_if import mpfb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic [COORD_W-1:0]        pos_x;
  logic [COORD_W-1:0]        pos_y;
  logic [CHAN_W-1:0]         channel;
  logic signed [DATA_W-1:0]  data_in;

  modport source (output valid, op, pos_x, pos_y, channel, data_in, input ready);
  modport sink (input valid, op, pos_x, pos_y, channel, data_in, output ready);
endinterface

interface mpfb_out_if import mpfb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  result_value;
  logic                      coord_error;

  modport source (output valid, result_value, coord_error, input ready);
  modport sink (input valid, result_value, coord_error, output ready);
endinterface

interface mpfb_cfg_if import mpfb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/max_pool_forward_backward.sv =====
// Max-pool forward/backward top level: sample and gradient stores plus the read sequencer.
//
// Writes of samples and output gradients are done on acceptance and leave the sequencer
// idle; an out-of-range request returns one result flagged coord_error through S_EMIT.
// A pooled read walks its k x k window through the sample store, one read per cycle,
// in S_MAX, then finishes the maximum in S_MAX_TAIL and emits it. An input-gradient read
// finds the covering windows in S_COVER, walks each the same way, and adds the output
// gradient in S_GRAD for each window whose maximum matches the sample. All window reads
// share the sample store's single read port. The block takes a new request only when
// its sequencer is idle; one finished result may wait in the output register meanwhile.
module max_pool_forward_backward import mpfb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  mpfb_in_if.sink    in_if,
  mpfb_out_if.source out_if,
  mpfb_cfg_if.sink   cfg_if
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [SIZE_W-1:0]  MAX_W_V = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0]  MAX_H_V = SIZE_W'(MAX_HEIGHT);
  localparam logic [DEPTH_W-1:0] MAX_D_V = DEPTH_W'(MAX_DEPTH);

  function automatic logic [ADDR_W-1:0] store_addr(logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y,
                                                   logic [CHAN_W-1:0]  c);
    return ADDR_W'((int'(c) * MAX_HEIGHT + int'(y)) * MAX_WIDTH + int'(x));
  endfunction

  logic [STRIDE_W-1:0] stride_r;
  logic [STRIDE_W-1:0] wsize_r;
  logic [SIZE_W-1:0]   width_r;
  logic [SIZE_W-1:0]   height_r;
  logic [DEPTH_W-1:0]  depth_r;

  logic [STRIDE_W-1:0] s_eff;
  logic [STRIDE_W-1:0] k_eff;
  logic [OFS_W-1:0]    km1;
  logic [SIZE_W-1:0]   w_eff;
  logic [SIZE_W-1:0]   h_eff;
  logic [DEPTH_W-1:0]  d_eff;
  logic [SIZE_W-1:0]   ow;
  logic [SIZE_W-1:0]   oh;

  logic in_acc;
  logic in_ok;
  logic out_ok;
  logic coord_ok;

  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [COORD_W-1:0]       x_r, x_nxt, y_r, y_nxt;
  logic [CHAN_W-1:0]        c_r, c_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [COORD_W-1:0]       gi_r, gi_nxt, gj_r, gj_nxt;
  logic [COORD_W-1:0]       x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [COORD_W-1:0]       bx_r, bx_nxt, by_r, by_nxt;
  logic [OFS_W-1:0]         wi_r, wi_nxt, wj_r, wj_nxt;
  logic                     pend_r, pend_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     err_r, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;
  logic                     out_err_r, out_err_nxt;

  logic [COORD_W-1:0]       win_x;
  logic [COORD_W-1:0]       win_y;
  logic [ADDR_W-1:0]        in_addr;
  logic [ADDR_W-1:0]        smp_raddr;
  logic [DATA_W-1:0]        smp_rdata;
  logic [DATA_W-1:0]        grd_rdata;
  logic signed [DATA_W-1:0] smp_q;
  logic signed [DATA_W-1:0] grd_q;
  logic signed [DATA_W-1:0] max_upd;
  logic signed [SUM_W-1:0]  sum_adv;
  logic                     do_adv;
  logic                     smp_we;
  logic                     grd_we;
  cover_t                   cov_x;
  cover_t                   cov_y;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= RST_POOL_STRIDE;
      wsize_r  <= RST_WINDOW_SIZE;
      width_r  <= RST_IN_WIDTH;
      height_r <= RST_IN_HEIGHT;
      depth_r  <= RST_IN_DEPTH;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        CFG_POOL_STRIDE: stride_r <= cfg_if.data[STRIDE_W-1:0];
        CFG_WINDOW_SIZE: wsize_r  <= cfg_if.data[STRIDE_W-1:0];
        CFG_IN_WIDTH:    width_r  <= cfg_if.data[SIZE_W-1:0];
        CFG_IN_HEIGHT:   height_r <= cfg_if.data[SIZE_W-1:0];
        CFG_IN_DEPTH:    depth_r  <= cfg_if.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (stride_r == '0) ? 3'd1 : ((stride_r > 3'd4) ? 3'd4 : stride_r);
    k_eff = (wsize_r == '0) ? 3'd1 : ((wsize_r > 3'd4) ? 3'd4 : wsize_r);
    km1   = OFS_W'(k_eff - 3'd1);
    w_eff = (width_r == '0) ? 7'd1 : ((width_r > MAX_W_V) ? MAX_W_V : width_r);
    h_eff = (height_r == '0) ? 7'd1 : ((height_r > MAX_H_V) ? MAX_H_V : height_r);
    d_eff = (depth_r == '0) ? 5'd1 : ((depth_r > MAX_D_V) ? MAX_D_V : depth_r);
    ow = (w_eff >= {4'b0, k_eff}) ? div_small(w_eff - {4'b0, k_eff}, s_eff) + 7'd1 : '0;
    oh = (h_eff >= {4'b0, k_eff}) ? div_small(h_eff - {4'b0, k_eff}, s_eff) + 7'd1 : '0;
  end

  // request decode
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    in_ok  = ({1'b0, in_if.pos_x} < w_eff) && ({1'b0, in_if.pos_y} < h_eff) &&
             ({1'b0, in_if.channel} < d_eff);
    out_ok = ({1'b0, in_if.pos_x} < ow) && ({1'b0, in_if.pos_y} < oh) &&
             ({1'b0, in_if.channel} < d_eff);
    coord_ok = (in_if.op == OP_WR_SAMPLE || in_if.op == OP_RD_GRAD) ? in_ok : out_ok;
  end

  // stores
  assign in_addr   = store_addr(in_if.pos_x, in_if.pos_y, in_if.channel);
  assign win_x     = bx_r + {{(COORD_W-OFS_W){1'b0}}, wi_r};
  assign win_y     = by_r + {{(COORD_W-OFS_W){1'b0}}, wj_r};
  assign smp_raddr = (state_r == S_IDLE) ? in_addr : store_addr(win_x, win_y, c_r);
  assign smp_we    = in_acc && coord_ok && (in_if.op == OP_WR_SAMPLE);
  assign grd_we    = in_acc && coord_ok && (in_if.op == OP_WR_GRAD);
  assign smp_q     = smp_rdata;
  assign grd_q     = grd_rdata;

  mpfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (in_addr),
    .wdata (in_if.data_in),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  mpfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_grd_ram (
    .clk   (clk),
    .we    (grd_we),
    .waddr (in_addr),
    .wdata (in_if.data_in),
    .raddr (store_addr(gi_r, gj_r, c_r)),
    .rdata (grd_rdata)
  );

  // shared compare unit and sequencer
  assign max_upd = (pend_r && (smp_q > max_r)) ? smp_q : max_r;
  assign cov_x   = cover_range(x_r, k_eff, s_eff, ow);
  assign cov_y   = cover_range(y_r, k_eff, s_eff, oh);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    c_nxt         = c_r;
    v_nxt         = v_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    gi_nxt        = gi_r;
    gj_nxt        = gj_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    wi_nxt        = wi_r;
    wj_nxt        = wj_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    pend_nxt      = (state_r == S_MAX);
    do_adv        = 1'b0;
    sum_adv       = sum_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_if.op;
          x_nxt   = in_if.pos_x;
          y_nxt   = in_if.pos_y;
          c_nxt   = in_if.channel;
          wi_nxt  = '0;
          wj_nxt  = '0;
          max_nxt = DATA_MIN;
          if (!coord_ok) begin
            res_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            unique case (in_if.op)
              OP_RD_POOL: begin
                bx_nxt    = mul_stride(in_if.pos_x, s_eff);
                by_nxt    = mul_stride(in_if.pos_y, s_eff);
                state_nxt = S_MAX;
              end
              OP_RD_GRAD: state_nxt = S_COVER;
              default:    state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_COVER: begin
        v_nxt   = smp_q;
        sum_nxt = '0;
        if (cov_x.empty || cov_y.empty) begin
          res_nxt   = '0;
          err_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          gi_nxt    = cov_x.lo;
          gj_nxt    = cov_y.lo;
          x1_nxt    = cov_x.hi;
          y0_nxt    = cov_y.lo;
          y1_nxt    = cov_y.hi;
          bx_nxt    = mul_stride(cov_x.lo, s_eff);
          by_nxt    = mul_stride(cov_y.lo, s_eff);
          wi_nxt    = '0;
          wj_nxt    = '0;
          max_nxt   = DATA_MIN;
          state_nxt = S_MAX;
        end
      end

      S_MAX: begin
        max_nxt = max_upd;
        if (wj_r == km1) begin
          wj_nxt = '0;
          if (wi_r == km1) begin
            state_nxt = S_MAX_TAIL;
          end else begin
            wi_nxt = wi_r + 2'd1;
          end
        end else begin
          wj_nxt = wj_r + 2'd1;
        end
      end

      S_MAX_TAIL: begin
        max_nxt = max_upd;
        if (op_r == OP_RD_POOL) begin
          res_nxt   = max_upd;
          err_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else if (max_upd == v_r) begin
          state_nxt = S_GRAD;
        end else begin
          do_adv = 1'b1;
        end
      end

      S_GRAD: begin
        sum_adv = sum_r + {{(SUM_W-DATA_W){grd_q[DATA_W-1]}}, grd_q};
        sum_nxt = sum_adv;
        do_adv  = 1'b1;
      end

      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // advance to the next covering window or finish
    if (do_adv) begin
      wi_nxt  = '0;
      wj_nxt  = '0;
      max_nxt = DATA_MIN;
      if (gj_r != y1_r) begin
        gj_nxt    = gj_r + 6'd1;
        by_nxt    = mul_stride(gj_r + 6'd1, s_eff);
        state_nxt = S_MAX;
      end else if (gi_r != x1_r) begin
        gi_nxt    = gi_r + 6'd1;
        gj_nxt    = y0_r;
        bx_nxt    = mul_stride(gi_r + 6'd1, s_eff);
        by_nxt    = mul_stride(y0_r, s_eff);
        state_nxt = S_MAX;
      end else begin
        res_nxt   = sat16(sum_adv);
        err_nxt   = 1'b0;
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    c_r       <= c_nxt;
    v_r       <= v_nxt;
    max_r     <= max_nxt;
    sum_r     <= sum_nxt;
    gi_r      <= gi_nxt;
    gj_r      <= gj_nxt;
    x1_r      <= x1_nxt;
    y0_r      <= y0_nxt;
    y1_r      <= y1_nxt;
    bx_r      <= bx_nxt;
    by_r      <= by_nxt;
    wi_r      <= wi_nxt;
    wj_r      <= wj_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_value = out_val_r;
  assign out_if.coord_error  = out_err_r;

  // checks
  a_win_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAX |-> ({1'b0, win_x} < w_eff) && ({1'b0, win_y} < h_eff))
    else $error("window element outside configured input");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.coord_error |-> out_if.result_value == '0)
    else $error("flagged result carries nonzero value");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && coord_ok && (in_if.op == OP_WR_SAMPLE || in_if.op == OP_WR_GRAD)
    |=> state_r == S_IDLE)
    else $error("valid write left sequencer busy");

  a_grad_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GRAD |-> $past(state_r) == S_MAX_TAIL)
    else $error("gradient fetch without matching window");

endmodule

// ===== hw/rtl/mpfb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mpfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
